>>> hdl/hsf_pkg.sv
// Package for the Horn-Schunck flow iteration: widths, codes, command and status types.
`default_nettype none
package hsf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int ALPHA_W  = 16;
  localparam int FWIDTH_W = 11;
  localparam int FHEIGHT_W = 16;
  localparam int FLOW_W   = 16;
  localparam int DER_W    = 13;
  localparam int DD_W     = 3 * DER_W;
  localparam int ROW_W    = 16;
  localparam int SUM_W    = 20;
  localparam int N_W      = 33;
  localparam int F_W      = 35;
  localparam int NUM_W    = 56;
  localparam int DEN_W    = 39;
  localparam int DVS_W    = DEN_W + 1;
  localparam int ACC_W    = 64;
  localparam int MB_W     = 21;
  localparam int CNT_W    = 7;
  localparam int TAPS     = 8;
  localparam int MUL_ITERS = MB_W;
  localparam int DIV_ITERS = ACC_W;

  localparam int REG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FWIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FHEIGHT = 2'd2;

  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_PREP, ST_DIV, ST_OUT
  } hsf_state_t;

  typedef enum logic [3:0] {
    MS_AA, MS_XX, MS_YY, MS_XU, MS_YV, MS_FU, MS_NX, MS_FV, MS_NY
  } hsf_mstep_t;

  typedef struct packed {
    logic       clear;
    logic       take;
    logic       rd_en;
    logic [2:0] rd_tap;
    logic       mul_load;
    logic       mul_iter;
    logic       mul_last;
    hsf_mstep_t mul_step;
    logic       prep;
    logic       div_load;
    logic       div_iter;
    logic       out_load;
  } hsf_cmd_t;

  typedef struct packed {
    logic emit;
    logic clr_done;
    logic out_free;
  } hsf_status_t;

  function automatic logic [FLOW_W-1:0] sat_q(input logic neg, input logic [ACC_W-1:0] q);
    logic [ACC_W-1:0] nq;
    nq = ~q + 64'd1;
    if (neg) begin
      sat_q = (q > 64'd32768) ? 16'h8000 : nq[FLOW_W-1:0];
    end else begin
      sat_q = (q > 64'd32767) ? 16'h7fff : q[FLOW_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/hsf_ifs.sv
// Stream and configuration channel interfaces for the flow iteration block.
`default_nettype none
interface hsf_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [hsf_pkg::FLOW_W-1:0] flow_u;
  logic signed [hsf_pkg::FLOW_W-1:0] flow_v;
  logic signed [hsf_pkg::DER_W-1:0]  deriv_x;
  logic signed [hsf_pkg::DER_W-1:0]  deriv_y;
  logic signed [hsf_pkg::DER_W-1:0]  deriv_t;
  modport source(output valid, req_type, flow_u, flow_v, deriv_x, deriv_y, deriv_t,
                 input ready);
  modport sink(input valid, req_type, flow_u, flow_v, deriv_x, deriv_y, deriv_t,
               output ready);
endinterface

interface hsf_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [hsf_pkg::FLOW_W-1:0] next_u;
  logic signed [hsf_pkg::FLOW_W-1:0] next_v;
  logic                              frame_end;
  modport source(output valid, next_u, next_v, frame_end, input ready);
  modport sink(input valid, next_u, next_v, frame_end, output ready);
endinterface

interface hsf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [hsf_pkg::REG_IDX_W-1:0]       reg_index;
  logic [hsf_pkg::CFG_DATA_W-1:0]      wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

>>> hdl/hsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2051
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/hsf_ctrl.sv
// Controller state machine sequencing clear, window read, multiply, divide and output.
`default_nettype none
module hsf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire hsf_pkg::hsf_status_t st,
  output hsf_pkg::hsf_cmd_t         cmd
);
  import hsf_pkg::*;

  hsf_state_t       state, state_next;
  logic [CNT_W-1:0] cnt;
  hsf_mstep_t       step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      step  <= MS_AA;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else if (state == ST_MUL && cnt == CNT_W'(MUL_ITERS)) begin
        cnt  <= '0;
        step <= hsf_mstep_t'(step + 4'd1);
      end else begin
        cnt <= cnt + 7'd1;
      end
      if (state == ST_READ) begin
        step <= MS_AA;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (st.clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid && st.emit) state_next = ST_READ;
      ST_READ:  if (cnt == CNT_W'(TAPS)) state_next = ST_MUL;
      ST_MUL:   if (cnt == CNT_W'(MUL_ITERS) && step == MS_NY) state_next = ST_PREP;
      ST_PREP:  state_next = ST_DIV;
      ST_DIV:   if (cnt == CNT_W'(DIV_ITERS)) state_next = ST_OUT;
      ST_OUT:   if (st.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.take  = req_valid;
      end
      ST_READ: begin
        cmd.rd_en  = cnt < CNT_W'(TAPS);
        cmd.rd_tap = cnt[2:0];
      end
      ST_MUL: begin
        cmd.mul_load = cnt == '0;
        cmd.mul_iter = cnt != '0;
        cmd.mul_last = cnt == CNT_W'(MUL_ITERS);
        cmd.mul_step = step;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_DIV: begin
        cmd.div_load = cnt == '0;
        cmd.div_iter = cnt != '0;
      end
      ST_OUT: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/hsf_datapath.sv
// Datapath: configuration, flow histories, window sums, serial multiplier and divider.
`default_nettype none
module hsf_datapath #(
  parameter int MAX_WIDTH = hsf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hsf_pkg::hsf_cmd_t                   cmd,
  output hsf_pkg::hsf_status_t                     st,
  input  wire logic                                cfg_we,
  input  wire logic [hsf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [hsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                req_type,
  input  wire logic signed [hsf_pkg::FLOW_W-1:0]   flow_u,
  input  wire logic signed [hsf_pkg::FLOW_W-1:0]   flow_v,
  input  wire logic signed [hsf_pkg::DER_W-1:0]    deriv_x,
  input  wire logic signed [hsf_pkg::DER_W-1:0]    deriv_y,
  input  wire logic signed [hsf_pkg::DER_W-1:0]    deriv_t,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [hsf_pkg::FLOW_W-1:0]        next_u,
  output logic signed [hsf_pkg::FLOW_W-1:0]        next_v,
  output logic                                     frame_end
);
  import hsf_pkg::*;

  localparam int HIST  = 2 * MAX_WIDTH + 3;
  localparam int AW    = $clog2(HIST);
  localparam int WC_W  = $clog2(MAX_WIDTH + 1);
  localparam int PC_W  = $clog2(MAX_WIDTH + 3);
  localparam int OFF_W = AW + 2;

  logic [ALPHA_W-1:0]   alpha;
  logic [FWIDTH_W-1:0]  frame_width;
  logic [FHEIGHT_W-1:0] frame_height;
  logic [AW-1:0]        wr_ptr;
  logic [PC_W-1:0]      pending;
  logic [WC_W-1:0]      col;
  logic [ROW_W-1:0]     row;
  logic [AW-1:0]        base_p;
  logic signed [SUM_W-1:0] acc_u, acc_v;
  logic                 rd_q;
  logic [2:0]           tap_q;

  logic signed [ACC_W-1:0] m_a, m_acc, acc_next;
  logic signed [MB_W-1:0]  m_b;
  logic [31:0]             p_aa;
  logic [25:0]             p_xx, p_yy;
  logic signed [N_W-1:0]   p_xu, p_yv;
  logic signed [NUM_W-1:0] p_fu, p_fv;
  logic signed [47:0]      p_nx, p_ny;

  logic signed [NUM_W-1:0] num_u, num_v;
  logic [DEN_W-1:0]        den;
  logic [DVS_W-1:0]        dvs;
  logic [ACC_W-1:0]        quot_u, quot_v;
  logic [DVS_W-1:0]        rem_u, rem_v;
  logic                    neg_u, neg_v;

  logic [WC_W-1:0]  eff_w;
  logic [16:0]      eff_h;
  logic [31:0]      fw32;
  logic             dl, dr, du, dd, last_col, last_row;
  logic signed [OFF_W-1:0] wv, off, addr_s, base_s;
  logic [AW-1:0]    rd_addr;
  logic [FLOW_W-1:0] u_rd, v_rd;
  logic [DD_W-1:0]  d_rd;
  logic signed [DER_W-1:0] dx, dy, dt;
  logic [F_W-1:0]   f_val;
  logic             fzero;
  logic signed [N_W-1:0] n_val;
  logic signed [ACC_W-1:0] a_sel;
  logic signed [MB_W-1:0]  b_sel;
  logic             pix_we;
  logic [NUM_W-1:0] mag_u, mag_v;
  logic [DVS_W:0]   sh_u, sh_v;
  logic [DVS_W+1:0] tr_u, tr_v;

  always_comb begin
    fw32 = 32'(frame_width);
    if (fw32 == 32'd0) begin
      eff_w = WC_W'(1);
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      eff_w = WC_W'(MAX_WIDTH);
    end else begin
      eff_w = WC_W'(fw32);
    end
    eff_h = (frame_height == '0) ? 17'd1 : 17'(frame_height);
  end

  assign dl       = col != '0;
  assign dr       = 32'(col) + 32'd1 < 32'(eff_w);
  assign du       = row != '0;
  assign dd       = 17'(row) + 17'd1 < eff_h;
  assign last_col = 32'(col) + 32'd1 >= 32'(eff_w);
  assign last_row = 17'(row) + 17'd1 >= eff_h;
  assign wv       = OFF_W'(eff_w);

  always_comb begin
    case (cmd.rd_tap)
      3'd0:    off = -OFF_W'(dl);
      3'd1:    off = OFF_W'(dr);
      3'd2:    off = du ? -wv : '0;
      3'd3:    off = dd ? wv : '0;
      3'd4:    off = (du ? -wv : '0) - OFF_W'(dl);
      3'd5:    off = OFF_W'(dr) - (du ? wv : '0);
      3'd6:    off = (dd ? wv : '0) - OFF_W'(dl);
      3'd7:    off = (dd ? wv : '0) + OFF_W'(dr);
      default: off = '0;
    endcase
    addr_s = OFF_W'(base_p) + off;
    if (addr_s < 0) begin
      addr_s = addr_s + OFF_W'(HIST);
    end else if (addr_s >= OFF_W'(HIST)) begin
      addr_s = addr_s - OFF_W'(HIST);
    end
    rd_addr = addr_s[AW-1:0];
    base_s = OFF_W'(wr_ptr) - OFF_W'(pending);
    if (base_s < 0) begin
      base_s = base_s + OFF_W'(HIST);
    end
  end

  assign pix_we = cmd.take && req_type != REQ_FLUSH;

  hsf_ram #(.WIDTH(FLOW_W), .DEPTH(HIST)) u_ram (
    .clk, .we(cmd.clear | pix_we), .waddr(wr_ptr),
    .wdata(cmd.clear ? '0 : flow_u), .raddr(rd_addr), .rdata(u_rd)
  );
  hsf_ram #(.WIDTH(FLOW_W), .DEPTH(HIST)) v_ram (
    .clk, .we(cmd.clear | pix_we), .waddr(wr_ptr),
    .wdata(cmd.clear ? '0 : flow_v), .raddr(rd_addr), .rdata(v_rd)
  );
  hsf_ram #(.WIDTH(DD_W), .DEPTH(HIST)) d_ram (
    .clk, .we(pix_we), .waddr(wr_ptr),
    .wdata({deriv_t, deriv_y, deriv_x}), .raddr(base_p), .rdata(d_rd)
  );

  assign dx = $signed(d_rd[DER_W-1:0]);
  assign dy = $signed(d_rd[2*DER_W-1:DER_W]);
  assign dt = $signed(d_rd[DD_W-1:2*DER_W]);

  assign f_val = F_W'(p_aa) + (F_W'(p_xx) << 8) + (F_W'(p_yy) << 8);
  assign fzero = f_val == '0;
  assign n_val = p_xu + p_yv + (N_W'(dt) <<< 11) + (N_W'(dt) <<< 10);

  always_comb begin
    case (cmd.mul_step)
      MS_AA: begin
        a_sel = ACC_W'($signed({1'b0, alpha}));
        b_sel = MB_W'($signed({1'b0, alpha}));
      end
      MS_XX:   begin a_sel = ACC_W'(dx);    b_sel = MB_W'(dx); end
      MS_YY:   begin a_sel = ACC_W'(dy);    b_sel = MB_W'(dy); end
      MS_XU:   begin a_sel = ACC_W'(acc_u); b_sel = MB_W'(dx); end
      MS_YV:   begin a_sel = ACC_W'(acc_v); b_sel = MB_W'(dy); end
      MS_FU:   begin a_sel = ACC_W'($signed({1'b0, f_val})); b_sel = MB_W'(acc_u); end
      MS_NX:   begin a_sel = ACC_W'(n_val); b_sel = MB_W'(dx); end
      MS_FV:   begin a_sel = ACC_W'($signed({1'b0, f_val})); b_sel = MB_W'(acc_v); end
      MS_NY:   begin a_sel = ACC_W'(n_val); b_sel = MB_W'(dy); end
      default: begin a_sel = '0; b_sel = '0; end
    endcase
    acc_next = m_acc;
    if (m_b[0]) begin
      acc_next = cmd.mul_last ? m_acc - m_a : m_acc + m_a;
    end
  end

  always_comb begin
    mag_u = num_u[NUM_W-1] ? NUM_W'(-num_u) : NUM_W'(num_u);
    mag_v = num_v[NUM_W-1] ? NUM_W'(-num_v) : NUM_W'(num_v);
    sh_u  = {rem_u, quot_u[ACC_W-1]};
    sh_v  = {rem_v, quot_v[ACC_W-1]};
    tr_u  = {1'b0, sh_u} - {2'b00, dvs};
    tr_v  = {1'b0, sh_v} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= 16'd256;
      frame_width  <= 11'd1024;
      frame_height <= 16'd1024;
      wr_ptr       <= '0;
      pending      <= '0;
      col          <= '0;
      row          <= '0;
      out_valid    <= 1'b0;
      rd_q         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA:   alpha        <= cfg_data;
          REG_FWIDTH:  frame_width  <= cfg_data[FWIDTH_W-1:0];
          REG_FHEIGHT: frame_height <= cfg_data;
          default:     ;
        endcase
      end
      if (cmd.clear || pix_we) begin
        wr_ptr <= (wr_ptr == AW'(HIST - 1)) ? '0 : wr_ptr + AW'(1);
      end
      rd_q <= cmd.rd_en;
      if (pix_we) begin
        pending <= pending + PC_W'(1);
      end else if (cmd.out_load) begin
        pending <= pending - PC_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 16'd1;
        end else begin
          col <= col + WC_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_q <= cmd.rd_tap;
    if (cmd.take) begin
      base_p <= base_s[AW-1:0];
      acc_u  <= '0;
      acc_v  <= '0;
    end else if (rd_q) begin
      acc_u <= acc_u + ((tap_q < 3'd4) ? (SUM_W'($signed(u_rd)) <<< 1) : SUM_W'($signed(u_rd)));
      acc_v <= acc_v + ((tap_q < 3'd4) ? (SUM_W'($signed(v_rd)) <<< 1) : SUM_W'($signed(v_rd)));
    end
    if (cmd.mul_load) begin
      m_a   <= a_sel;
      m_b   <= b_sel;
      m_acc <= '0;
    end else if (cmd.mul_iter) begin
      m_a   <= m_a <<< 1;
      m_b   <= m_b >>> 1;
      m_acc <= acc_next;
    end
    if (cmd.mul_last) begin
      case (cmd.mul_step)
        MS_AA:   p_aa <= acc_next[31:0];
        MS_XX:   p_xx <= acc_next[25:0];
        MS_YY:   p_yy <= acc_next[25:0];
        MS_XU:   p_xu <= acc_next[N_W-1:0];
        MS_YV:   p_yv <= acc_next[N_W-1:0];
        MS_FU:   p_fu <= acc_next[NUM_W-1:0];
        MS_NX:   p_nx <= acc_next[47:0];
        MS_FV:   p_fv <= acc_next[NUM_W-1:0];
        MS_NY:   p_ny <= acc_next[47:0];
        default: ;
      endcase
    end
    if (cmd.prep) begin
      num_u <= fzero ? NUM_W'(acc_u) : p_fu - (NUM_W'(p_nx) <<< 8);
      num_v <= fzero ? NUM_W'(acc_v) : p_fv - (NUM_W'(p_ny) <<< 8);
      den   <= fzero ? DEN_W'(12) : (DEN_W'(f_val) << 3) + (DEN_W'(f_val) << 2);
    end
    if (cmd.div_load) begin
      quot_u <= (ACC_W'(mag_u) << 1) + ACC_W'(den);
      quot_v <= (ACC_W'(mag_v) << 1) + ACC_W'(den);
      neg_u  <= num_u[NUM_W-1];
      neg_v  <= num_v[NUM_W-1];
      rem_u  <= '0;
      rem_v  <= '0;
      dvs    <= {den, 1'b0};
    end else if (cmd.div_iter) begin
      rem_u  <= tr_u[DVS_W+1] ? sh_u[DVS_W-1:0] : tr_u[DVS_W-1:0];
      rem_v  <= tr_v[DVS_W+1] ? sh_v[DVS_W-1:0] : tr_v[DVS_W-1:0];
      quot_u <= {quot_u[ACC_W-2:0], ~tr_u[DVS_W+1]};
      quot_v <= {quot_v[ACC_W-2:0], ~tr_v[DVS_W+1]};
    end
    if (cmd.out_load) begin
      next_u    <= $signed(sat_q(neg_u, quot_u));
      next_v    <= $signed(sat_q(neg_v, quot_v));
      frame_end <= last_col && last_row;
    end
  end

  assign st.emit     = (req_type == REQ_FLUSH) ? pending != '0
                                               : 32'(pending) > 32'(eff_w);
  assign st.clr_done = wr_ptr == AW'(HIST - 1);
  assign st.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pending) <= MAX_WIDTH + 2) else $error("pending count above window lag");
  a_wr_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(wr_ptr) < HIST) else $error("write pointer out of history range");
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result not presented after load");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !cmd.clear && !cmd.out_load) else $error("item taken while busy");
`endif
endmodule
`default_nettype wire

>>> hdl/horn_schunck_flow_iteration.sv
// Top level: one Horn-Schunck flow update over a raster pixel stream.
// An item that yields no result needs no further steps; an item that yields a result goes
// through 8 window reads, 9 serial 21-bit multiplies, prep, two side-by-side 64-step
// dividers, then output load into its result register.
// One item is worked on at a time; the output register holds a result while input is taken.
// After reset a clearing pass zeroes the flow histories.
`default_nettype none
module horn_schunck_flow_iteration #(
  parameter int MAX_WIDTH = hsf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  hsf_cfg_if.sink   cfg,
  hsf_req_if.sink   req,
  hsf_res_if.source res
);
  import hsf_pkg::*;

  hsf_cmd_t    cmd;
  hsf_status_t st;

  assign cfg.ready = 1'b1;

  hsf_ctrl u_ctrl (
    .clk, .rst, .req_valid(req.valid), .req_ready(req.ready), .st, .cmd
  );

  hsf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk, .rst, .cmd, .st,
    .cfg_we(cfg.valid), .cfg_index(cfg.reg_index), .cfg_data(cfg.wdata),
    .req_type(req.req_type), .flow_u(req.flow_u), .flow_v(req.flow_v),
    .deriv_x(req.deriv_x), .deriv_y(req.deriv_y), .deriv_t(req.deriv_t),
    .out_valid(res.valid), .out_ready(res.ready),
    .next_u(res.next_u), .next_v(res.next_v), .frame_end(res.frame_end)
  );
endmodule
`default_nettype wire

>>> tb/hsf_tb_pkg.sv
// Testbench package: pixel transfer and flow result types for the flow iteration testbench.
`timescale 1ns / 100ps
package hsf_tb_pkg;

  typedef struct {
    logic                              flush;
    logic signed [hsf_pkg::FLOW_W-1:0] u;
    logic signed [hsf_pkg::FLOW_W-1:0] v;
    logic signed [hsf_pkg::DER_W-1:0]  ex;
    logic signed [hsf_pkg::DER_W-1:0]  ey;
    logic signed [hsf_pkg::DER_W-1:0]  et;
  } pixel_t;

  typedef struct {
    logic signed [hsf_pkg::FLOW_W-1:0] nu;
    logic signed [hsf_pkg::FLOW_W-1:0] nv;
    logic                              fend;
  } flow_res_t;

endpackage

>>> tb/testbench.sv
// Self-checking testbench of the Horn-Schunck flow iteration: directed and random pixel frames.
`timescale 1ns / 100ps
module testbench;
  import hsf_pkg::*;
  import hsf_tb_pkg::*;

  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int HIST = 2 * MAXW + 3;
  localparam int SETTLE = 300;

  logic clk;
  logic rst;

  hsf_cfg_if cfg_ch();
  hsf_req_if req_ch();
  hsf_res_if res_ch();

  horn_schunck_flow_iteration u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .res(res_ch)
  );

  logic signed [FLOW_W-1:0] u_hist[HIST];
  logic signed [FLOW_W-1:0] v_hist[HIST];
  logic [DD_W-1:0]          d_hist[HIST];
  int unsigned wr_ptr, col_pos, row_pos, pend_cnt;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [FWIDTH_W-1:0]  fwidth_r;
  logic [FHEIGHT_W-1:0] fheight_r;

  flow_res_t expected_flow[$];
  int errors;
  int sent_cnt;
  int burst_left;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned eff_w();
    if (fwidth_r == 0) return 1;
    if (fwidth_r > MAXW) return MAXW;
    return fwidth_r;
  endfunction

  function automatic int unsigned eff_h();
    return (fheight_r == 0) ? 1 : fheight_r;
  endfunction

  function automatic longint tap(bit use_u, int unsigned base, int unsigned plus,
                                 int unsigned minus);
    int unsigned idx;
    idx = (base + plus + 2 * HIST - minus) % HIST;
    return use_u ? longint'(u_hist[idx]) : longint'(v_hist[idx]);
  endfunction

  function automatic longint window_sum(bit use_u, int unsigned p, int unsigned dl,
                                        int unsigned dr, int unsigned du, int unsigned dd);
    longint sides, corners;
    sides = tap(use_u, p, 0, dl) + tap(use_u, p, dr, 0) + tap(use_u, p, 0, du)
          + tap(use_u, p, dd, 0);
    corners = tap(use_u, p, 0, du + dl) + tap(use_u, p, dr, du) + tap(use_u, p, dd, dl)
            + tap(use_u, p, dd + dr, 0);
    return 2 * sides + corners;
  endfunction

  function automatic logic [FLOW_W-1:0] round_sat(longint p, longint d);
    bit neg;
    longint unsigned mag, q;
    neg = p < 0;
    mag = neg ? longint'(-p) : p;
    q = (2 * mag + d) / (2 * d);
    if (neg) begin
      if (q > 32768) q = 32768;
      return FLOW_W'(-q);
    end
    if (q > 32767) q = 32767;
    return FLOW_W'(q);
  endfunction

  function automatic void emit_flow_update();
    int unsigned w, h, p, dl, dr, du, dd;
    longint au, av, x, y, t, f, n;
    flow_res_t r;
    bit last_col, last_row;
    w = eff_w();
    h = eff_h();
    p = (wr_ptr + HIST - pend_cnt) % HIST;
    dl = col_pos > 0 ? 1 : 0;
    dr = col_pos + 1 < w ? 1 : 0;
    du = row_pos > 0 ? w : 0;
    dd = row_pos + 1 < h ? w : 0;
    au = window_sum(1'b1, p, dl, dr, du, dd);
    av = window_sum(1'b0, p, dl, dr, du, dd);
    x = longint'($signed(d_hist[p][DER_W-1:0]));
    y = longint'($signed(d_hist[p][2*DER_W-1:DER_W]));
    t = longint'($signed(d_hist[p][3*DER_W-1:2*DER_W]));
    f = longint'(alpha_r) * longint'(alpha_r) + 256 * (x * x + y * y);
    last_col = col_pos + 1 >= w;
    last_row = row_pos + 1 >= h;
    if (f == 0) begin
      r.nu = round_sat(au, 12);
      r.nv = round_sat(av, 12);
    end else begin
      n = x * au + y * av + 3072 * t;
      r.nu = round_sat(au * f - 256 * x * n, 12 * f);
      r.nv = round_sat(av * f - 256 * y * n, 12 * f);
    end
    r.fend = last_col && last_row;
    expected_flow.push_back(r);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    pend_cnt--;
  endfunction

  function automatic void predict_flow(pixel_t px);
    if (px.flush) begin
      if (pend_cnt != 0) emit_flow_update();
      return;
    end
    u_hist[wr_ptr] = px.u;
    v_hist[wr_ptr] = px.v;
    d_hist[wr_ptr] = {px.et, px.ey, px.ex};
    wr_ptr = (wr_ptr + 1) % HIST;
    pend_cnt++;
    if (pend_cnt > eff_w() + 1) emit_flow_update();
  endfunction

  task automatic report(string what, int got, int exp);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    flow_res_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_flow.size() == 0) begin
        report("unexpected result", res_ch.next_u, 0);
      end else begin
        e = expected_flow.pop_front();
        if (res_ch.next_u !== e.nu) report("next_u", res_ch.next_u, e.nu);
        if (res_ch.next_v !== e.nv) report("next_v", res_ch.next_v, e.nv);
        if (res_ch.frame_end !== e.fend) report("frame_end", res_ch.frame_end, e.fend);
      end
    end
  end

  // receiver: stall pattern re-drawn periodically at random, long hold-off on request
  initial begin
    int hold_cnt, mode, tick;
    hold_cnt = 0;
    mode = 0;
    tick = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_cnt = 3000;
        hold_req = 1'b0;
      end
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_ch.ready = 1'b0;
      end else if (mode == 0) begin
        res_ch.ready = 1'b1;
      end else if (mode == 1) begin
        res_ch.ready = 1'($urandom_range(0, 1));
      end else begin
        res_ch.ready = ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send_item(pixel_t px);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.req_type = px.flush;
    req_ch.flow_u = px.u;
    req_ch.flow_v = px.v;
    req_ch.deriv_x = px.ex;
    req_ch.deriv_y = px.ey;
    req_ch.deriv_t = px.et;
    do @(posedge clk); while (!req_ch.ready);
    predict_flow(px);
    sent_cnt++;
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    req_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic offer(pixel_t px);
    send_item(px);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 20);
    end
  endtask

  task automatic settle();
    idle_cycles(1);
    while (expected_flow.size() != 0) @(posedge clk);
    idle_cycles(SETTLE);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wdata = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ALPHA: alpha_r = val;
      REG_FWIDTH: fwidth_r = val[FWIDTH_W-1:0];
      REG_FHEIGHT: fheight_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(logic [15:0] a, logic [15:0] w, logic [15:0] h);
    settle();
    write_reg(REG_ALPHA, a);
    write_reg(REG_FWIDTH, w);
    write_reg(REG_FHEIGHT, h);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.flush = 1'b0;
    px.u = 16'($urandom);
    px.v = 16'($urandom);
    px.ex = 13'($urandom);
    px.ey = 13'($urandom);
    px.et = 13'($urandom);
    case ($urandom_range(0, 7))
      0: begin px.ex = '0; px.ey = '0; end
      1: begin
        px.u = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        px.v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      2: begin
        px.ex = $urandom_range(0, 1) ? 13'sh0fff : 13'sh1000;
        px.ey = $urandom_range(0, 1) ? 13'sh0fff : 13'sh1000;
        px.et = $urandom_range(0, 1) ? 13'sh0fff : 13'sh1000;
      end
      3: begin
        px.u = 16'(int'($urandom_range(0, 1024)) - 512);
        px.v = 16'(int'($urandom_range(0, 1024)) - 512);
        px.ex = 13'(int'($urandom_range(0, 64)) - 32);
        px.ey = 13'(int'($urandom_range(0, 64)) - 32);
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic pixel_t flush_item();
    pixel_t px;
    px = rand_pixel();
    px.flush = REQ_FLUSH;
    return px;
  endfunction

  task automatic drain_pending(bit extra);
    while (pend_cnt != 0) offer(flush_item());
    if (extra) offer(flush_item());
  endtask

  task automatic test_reset_values();
    pixel_t px;
    px = rand_pixel();
    px.u = 16'sh7fff; px.v = 16'sh8000;
    px.ex = 13'sh0fff; px.ey = 13'sh1000; px.et = 13'sh0fff;
    offer(px);
    px.u = 16'sh8000; px.v = 16'sh7fff;
    px.ex = 13'sh1000; px.ey = 13'sh0fff; px.et = 13'sh1000;
    offer(px);
    repeat (3) offer(rand_pixel());
    drain_pending(1'b1);
  endtask

  task automatic test_zero_divisor();
    pixel_t px;
    configure(16'd0, 16'd3, 16'd2);
    for (int i = 0; i < 6; i++) begin
      px = rand_pixel();
      px.ex = '0; px.ey = '0;
      px.u = (i % 2) ? 16'sh7fff : 16'sh8000;
      offer(px);
    end
    drain_pending(1'b1);
  endtask

  task automatic test_size_limits();
    configure(16'hffff, 16'd0, 16'd0);
    repeat (4) offer(rand_pixel());
    drain_pending(1'b0);
    configure(16'd1, 16'd2047, 16'hffff);
    repeat (4) offer(rand_pixel());
    drain_pending(1'b1);
  endtask

  task automatic test_frames_without_flush();
    configure(16'd256, 16'd3, 16'd2);
    repeat (12) offer(rand_pixel());
    drain_pending(1'b0);
  endtask

  task automatic test_write_mid_frame();
    configure(16'd512, 16'd4, 16'd3);
    repeat (7) offer(rand_pixel());
    settle();
    write_reg(REG_ALPHA, 16'd40);
    repeat (5) offer(rand_pixel());
    drain_pending(1'b0);
  endtask

  task automatic test_output_backpressure();
    configure(16'd128, 16'd2, 16'd3);
    @(posedge clk);
    hold_req = 1'b1;
    burst_left = 40;
    repeat (30) send_item(rand_pixel());
    drain_pending(1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int start, frames, rows;
    logic [15:0] a, w, h;
    start = sent_cnt;
    while (sent_cnt - start < 1350) begin
      case ($urandom_range(0, 5))
        0: a = 16'd0;
        1: a = 16'hffff;
        default: a = 16'($urandom);
      endcase
      w = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1))
                                        : 16'($urandom_range(1, 8));
      if ($urandom_range(0, 20) == 0) w = 16'd2047;
      case ($urandom_range(0, 9))
        0: h = 16'd0;
        1: h = 16'hffff;
        default: h = 16'($urandom_range(1, 5));
      endcase
      configure(a, w, h);
      frames = $urandom_range(1, 3);
      rows = (eff_h() > 6) ? 2 : eff_h();
      if (eff_w() > 8) rows = 0;
      for (int fr = 0; fr < frames; fr++) begin
        for (int i = 0; i < eff_w() * rows; i++) begin
          if ($urandom_range(0, 29) == 0) offer(flush_item());
          offer(rand_pixel());
        end
        if (eff_w() > 8) repeat (6) offer(rand_pixel());
      end
      if ($urandom_range(0, 4) != 0) drain_pending($urandom_range(0, 1));
    end
    drain_pending(1'b1);
  endtask

  initial begin
    errors = 0;
    sent_cnt = 0;
    burst_left = 0;
    hold_req = 1'b0;
    alpha_r = 16'd256;
    fwidth_r = 11'd1024;
    fheight_r = 16'd1024;
    wr_ptr = 0; col_pos = 0; row_pos = 0; pend_cnt = 0;
    for (int i = 0; i < HIST; i++) begin
      u_hist[i] = '0;
      v_hist[i] = '0;
      d_hist[i] = '0;
    end
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.flow_u = '0;
    req_ch.flow_v = '0;
    req_ch.deriv_x = '0;
    req_ch.deriv_y = '0;
    req_ch.deriv_t = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_ALPHA;
    cfg_ch.wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_zero_divisor();
    test_size_limits();
    test_frames_without_flush();
    test_write_mid_frame();
    test_output_backpressure();
    test_random_frames();

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> horn_schunck_flow_iteration.f
hdl/hsf_pkg.sv
hdl/hsf_ifs.sv
hdl/hsf_ram.sv
hdl/hsf_ctrl.sv
hdl/hsf_datapath.sv
hdl/horn_schunck_flow_iteration.sv
tb/hsf_tb_pkg.sv
tb/testbench.sv
